/* design/assert_macros.svh */
// Assertion macros shared by the RTL files of the vertex normal block.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mvna_pkg.sv */
// Types and fixed constants for the vertex normal accumulator.
// No dependencies; used by mvna_norm and the top level through scoped names, and imported by the testbench.
`timescale 1ns / 1ps
`default_nettype none

package mvna_pkg;

    // Field widths of the item formats
    localparam int OPC_W      = 2;
    localparam int IDX_IN_W   = 10;
    localparam int POS_W      = 20;
    localparam int CNT_W      = 11;
    localparam int Q15_W      = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [OPC_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OPC_W-1:0] OP_TRI  = 2'd1;
    localparam logic [OPC_W-1:0] OP_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WATER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFS_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFS_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFS_Z  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT = 3'd5;

    // Normaliser: the largest magnitude is scaled into [2^NORM_LO, 2^NORM_HI)
    localparam int NORM_LO    = 29;
    localparam int NORM_HI    = 30;
    localparam int NORM_OP_W  = 31;   // signed multiplier operand for a scaled magnitude
    localparam int SQ_W       = 62;   // sum of three squares
    localparam int ROOT_STEPS = 31;
    localparam int ROOT_W     = 31;   // integer root of SQ_W bits
    localparam int FRAC_W     = 15;
    localparam int QUO_W      = 17;   // quotient bits, clamped afterwards
    localparam int NUM_W      = 46;   // m * 2^15 + n / 2

    localparam logic [SQ_W-1:0]  ROOT_START = SQ_W'(1) << (2 * (ROOT_STEPS - 1));
    localparam logic [Q15_W-1:0] Q15_MAX    = 16'h7FFF;

    typedef struct packed {
        logic [OPC_W-1:0]        opcode;
        logic [IDX_IN_W-1:0]     vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_IN_W-1:0]     corner_a;
        logic [IDX_IN_W-1:0]     corner_b;
        logic [IDX_IN_W-1:0]     corner_c;
    } in_item_t;

    typedef struct packed {
        logic signed [Q15_W-1:0] normal_x;
        logic signed [Q15_W-1:0] normal_y;
        logic signed [Q15_W-1:0] normal_z;
        logic [IDX_IN_W-1:0]     normal_index;
        logic                    zero_normal;
    } out_item_t;

    // Result of the normaliser
    typedef struct packed {
        logic signed [Q15_W-1:0] x;
        logic signed [Q15_W-1:0] y;
        logic signed [Q15_W-1:0] z;
        logic                    zero;
    } norm_res_t;

endpackage

`default_nettype wire

/* design/mvna_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mvna_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/mvna_mul.sv */
// Shared signed multiplier with a registered product.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mvna_mul #(
    parameter int W = 32
) (
    input  logic                  clk,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);

    logic signed [2*W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* design/mvna_norm.sv */
// Iterative normaliser: scale, sum of squares, integer root, Q1.15 divide.
// Depends on mvna_pkg; borrows the shared multiplier through mul_a/mul_b/mul_p.
`timescale 1ns / 1ps
`default_nettype none

module mvna_norm #(
    parameter int VEC_W = 58,
    parameter int MUL_W = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [VEC_W-1:0] vec_x,
    input  logic signed [VEC_W-1:0] vec_y,
    input  logic signed [VEC_W-1:0] vec_z,
    output logic signed [MUL_W-1:0] mul_a,
    output logic signed [MUL_W-1:0] mul_b,
    input  logic [2*MUL_W-1:0]      mul_p,
    output logic                    done,
    output mvna_pkg::norm_res_t     res
);

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SCALE = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_ROOT  = 3'd3;
    localparam logic [2:0] N_DIV   = 3'd4;
    localparam logic [2:0] N_DONE  = 3'd5;

    localparam int HI = mvna_pkg::NORM_HI;
    localparam int RW = mvna_pkg::ROOT_W;
    localparam int QW = mvna_pkg::QUO_W;

    logic [2:0]              st_reg;
    logic [4:0]              cnt_reg;
    logic [1:0]              k_reg;
    logic [VEC_W-1:0]        mx_reg, my_reg, mz_reg;
    logic                    neg_x_reg, neg_y_reg, neg_z_reg;
    logic [mvna_pkg::SQ_W-1:0] sq_reg, rad_reg, r_reg, bit_reg;
    logic [RW-1:0]           n_reg;
    logic [RW-1:0]           rem_reg;
    logic [QW-1:0]           dnum_reg, q_reg;
    mvna_pkg::norm_res_t     res_reg;

    logic [VEC_W-1:0]        ax, ay, az, or_m;
    logic [HI-1:0]           m_sel;
    logic                    neg_sel;
    logic [mvna_pkg::SQ_W:0] try_sum;
    logic                    root_ge;
    logic [mvna_pkg::NUM_W-1:0] num;
    logic [RW:0]             div_t;
    logic                    div_ge;
    logic [QW-1:0]           q_fin;
    logic [mvna_pkg::Q15_W-1:0] q_clamp;
    logic signed [mvna_pkg::Q15_W-1:0] q_enc;

    // Magnitudes of the incoming vector
    always_comb
    begin
        ax = vec_x[VEC_W-1] ? VEC_W'(-vec_x) : VEC_W'(vec_x);
        ay = vec_y[VEC_W-1] ? VEC_W'(-vec_y) : VEC_W'(vec_y);
        az = vec_z[VEC_W-1] ? VEC_W'(-vec_z) : VEC_W'(vec_z);
        or_m = mx_reg | my_reg | mz_reg;
    end

    // Component picked by the square counter or the divide counter
    always_comb
    begin
        case ((st_reg == N_SQ) ? cnt_reg[1:0] : k_reg)
            2'd0:
            begin
                m_sel   = mx_reg[HI-1:0];
                neg_sel = neg_x_reg;
            end
            2'd1:
            begin
                m_sel   = my_reg[HI-1:0];
                neg_sel = neg_y_reg;
            end
            default:
            begin
                m_sel   = mz_reg[HI-1:0];
                neg_sel = neg_z_reg;
            end
        endcase
    end

    assign mul_a = MUL_W'(m_sel);
    assign mul_b = MUL_W'(m_sel);

    // One step of the bit-pair square root
    always_comb
    begin
        try_sum = {1'b0, r_reg} + {1'b0, bit_reg};
        root_ge = {1'b0, rad_reg} >= try_sum;
    end

    // One step of the restoring divide, plus the Q1.15 encoding
    always_comb
    begin
        num     = mvna_pkg::NUM_W'({m_sel, {mvna_pkg::FRAC_W{1'b0}}})
                + mvna_pkg::NUM_W'(n_reg >> 1);
        div_t   = {rem_reg, dnum_reg[QW-1]};
        div_ge  = div_t >= {1'b0, n_reg};
        q_fin   = {q_reg[QW-2:0], div_ge};
        q_clamp = (q_fin > QW'(mvna_pkg::Q15_MAX)) ? mvna_pkg::Q15_MAX
                                                   : q_fin[mvna_pkg::Q15_W-1:0];
        q_enc   = neg_sel ? -$signed(q_clamp) : $signed(q_clamp);
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= N_IDLE;
            cnt_reg <= '0;
            k_reg   <= '0;
        end
        else
        begin
            case (st_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        st_reg  <= ((ax | ay | az) == '0) ? N_DONE : N_SCALE;
                        cnt_reg <= '0;
                        k_reg   <= '0;
                    end
                end
                N_SCALE:
                begin
                    if (!(|or_m[VEC_W-1:HI]) && or_m[mvna_pkg::NORM_LO])
                    begin
                        st_reg  <= N_SQ;
                        cnt_reg <= '0;
                    end
                end
                N_SQ:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd3)
                    begin
                        st_reg  <= N_ROOT;
                        cnt_reg <= '0;
                    end
                end
                N_ROOT:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(mvna_pkg::ROOT_STEPS - 1))
                    begin
                        st_reg  <= N_DIV;
                        cnt_reg <= '0;
                    end
                end
                N_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(QW))
                    begin
                        cnt_reg <= '0;
                        k_reg   <= k_reg + 2'd1;
                        if (k_reg == 2'd2)
                        begin
                            st_reg <= N_DONE;
                        end
                    end
                end
                N_DONE:
                begin
                    st_reg <= N_IDLE;
                end
                default:
                begin
                    st_reg <= N_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (st_reg)
            N_IDLE:
            begin
                mx_reg    <= ax;
                my_reg    <= ay;
                mz_reg    <= az;
                neg_x_reg <= vec_x[VEC_W-1];
                neg_y_reg <= vec_y[VEC_W-1];
                neg_z_reg <= vec_z[VEC_W-1];
                res_reg   <= '{x: '0, y: '0, z: '0, zero: 1'b1};
            end
            N_SCALE:
            begin
                // one bit a cycle, truncating on the way down
                if (|or_m[VEC_W-1:HI])
                begin
                    mx_reg <= mx_reg >> 1;
                    my_reg <= my_reg >> 1;
                    mz_reg <= mz_reg >> 1;
                end
                else if (!or_m[mvna_pkg::NORM_LO])
                begin
                    mx_reg <= mx_reg << 1;
                    my_reg <= my_reg << 1;
                    mz_reg <= mz_reg << 1;
                end
            end
            N_SQ:
            begin
                // product of the previous count arrives now
                if (cnt_reg == 5'd1)
                begin
                    sq_reg <= mul_p[mvna_pkg::SQ_W-1:0];
                end
                else if (cnt_reg == 5'd2)
                begin
                    sq_reg <= sq_reg + mul_p[mvna_pkg::SQ_W-1:0];
                end
                else if (cnt_reg == 5'd3)
                begin
                    rad_reg <= sq_reg + mul_p[mvna_pkg::SQ_W-1:0];
                    r_reg   <= '0;
                    bit_reg <= mvna_pkg::ROOT_START;
                end
            end
            N_ROOT:
            begin
                if (root_ge)
                begin
                    rad_reg <= rad_reg - try_sum[mvna_pkg::SQ_W-1:0];
                    r_reg   <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                res_reg.zero <= 1'b0;
                n_reg <= root_ge ? RW'((r_reg >> 1) + bit_reg) : RW'(r_reg >> 1);
            end
            N_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    rem_reg  <= RW'(num[mvna_pkg::NUM_W-1:QW]);
                    dnum_reg <= num[QW-1:0];
                    q_reg    <= '0;
                end
                else
                begin
                    rem_reg  <= div_ge ? RW'(div_t - {1'b0, n_reg}) : div_t[RW-1:0];
                    dnum_reg <= dnum_reg << 1;
                    q_reg    <= q_fin;
                    if (cnt_reg == 5'(QW))
                    begin
                        case (k_reg)
                            2'd0:    res_reg.x <= q_enc;
                            2'd1:    res_reg.y <= q_enc;
                            default: res_reg.z <= q_enc;
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done = (st_reg == N_DONE);
    assign res  = res_reg;

endmodule

`default_nettype wire

/* design/mesh_vertex_normal_accumulator.sv */
// Top level of the area-weighted vertex normal accumulator.
// Depends on mvna_pkg, mvna_ram, mvna_mul, mvna_norm and assert_macros.svh.
//
//  channel  | signals                          | item
//  ---------+----------------------------------+----------------------------
//  input    | in_valid, in_stall, in_item      | mvna_pkg::in_item_t
//  output   | out_valid, out_stall, out_item   | mvna_pkg::out_item_t
//  config   | cfg_we, cfg_index, cfg_data      | register write, no read-back
//
// A load item, a skipped triangle or an unused opcode leaves the sequencer idle, and a
// triangle runs three vertex reads, six products on the one multiplier and three
// read-modify-writes of the sum RAM through its single port pair.
// A read waits on the normaliser: one scaling shift a cycle, a 31-step root and three
// 17-step divides; a flat water read skips the normaliser.
// After a read, in_stall is high until the result sits in the output register; a result
// waiting there does not hold off the next item. Reset clears control and config only.
`timescale 1ns / 1ps
`default_nettype none

module mesh_vertex_normal_accumulator #(
    parameter int MAX_VERTS  = 1024,
    parameter int COORD_BITS = 20,
    parameter int SUM_BITS   = 56
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mvna_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mvna_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [mvna_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mvna_pkg::CFG_DATA_W-1:0]     cfg_data
);

`include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_VERTS);
    localparam int POS_W = mvna_pkg::POS_W;
    localparam int D_W   = COORD_BITS + 1;
    localparam int CR_W  = 2 * D_W + 1;
    localparam int ACC_W = ((SUM_BITS > CR_W) ? SUM_BITS : CR_W) + 1;
    localparam int WV_W  = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 1;
    localparam int VEC_W = ((SUM_BITS > WV_W) ? SUM_BITS : WV_W) + 1;
    localparam int MUL_W = ((D_W > mvna_pkg::NORM_OP_W) ? D_W : mvna_pkg::NORM_OP_W) + 1;
    localparam int VR_W  = 3 * COORD_BITS;
    localparam int SR_W  = 3 * SUM_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TRI   = 3'd1;
    localparam logic [2:0] S_CROSS = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_NORM  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // Configuration registers
    logic                               water_mode_reg, flat_world_reg;
    logic signed [POS_W-1:0]            offset_x_reg, offset_y_reg, offset_z_reg;
    logic [mvna_pkg::CNT_W-1:0]         vcount_reg;

    // Sequencer and item registers
    logic [2:0]                 state_reg;
    logic [2:0]                 step_reg;
    mvna_pkg::in_item_t         item_reg;
    logic [VR_W-1:0]            va_reg, vb_reg;
    logic signed [D_W-1:0]      u_reg [3];
    logic signed [D_W-1:0]      v_reg [3];
    logic signed [CR_W-1:0]     cr_reg [3];
    logic signed [CR_W-1:0]     pm_reg;
    mvna_pkg::out_item_t        res_reg, out_item_reg;
    logic                       out_valid_reg;

    // Combinational signals
    logic                       in_acc;
    logic                       vi_ok, skip_tri, item_vi_ok;
    logic [COORD_BITS-1:0]      ld_x, ld_y, ld_z;
    logic                       vert_we, sum_we, acc_we;
    logic [IDX_W-1:0]           vert_raddr, sum_raddr, corner_addr, ld_addr;
    logic [VR_W-1:0]            vert_rdata;
    logic [SR_W-1:0]            sum_rdata, acc_data;
    logic signed [D_W-1:0]      u_next [3];
    logic signed [D_W-1:0]      v_next [3];
    logic signed [MUL_W-1:0]    cr_a, cr_b, nm_a, nm_b, mul_a, mul_b;
    logic signed [2*MUL_W-1:0]  mul_p;
    logic signed [CR_W-1:0]     prod;
    logic signed [VEC_W-1:0]    vec [3];
    logic                       norm_start, norm_done;
    mvna_pkg::norm_res_t        norm_res;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // Range checks on the incoming item
    always_comb
    begin
        vi_ok      = (32'(in_item.vertex_index) < MAX_VERTS);
        item_vi_ok = (32'(item_reg.vertex_index) < MAX_VERTS);
        skip_tri   = ({1'b0, in_item.corner_a} >= vcount_reg)
                  || ({1'b0, in_item.corner_b} >= vcount_reg)
                  || ({1'b0, in_item.corner_c} >= vcount_reg)
                  || (32'(in_item.corner_a) >= MAX_VERTS)
                  || (32'(in_item.corner_b) >= MAX_VERTS)
                  || (32'(in_item.corner_c) >= MAX_VERTS);
    end

    // Load coordinates taken as COORD_BITS two's complement
    if (COORD_BITS <= POS_W)
    begin : g_crd_trunc
        assign ld_x = in_item.pos_x[COORD_BITS-1:0];
        assign ld_y = in_item.pos_y[COORD_BITS-1:0];
        assign ld_z = in_item.pos_z[COORD_BITS-1:0];
    end
    else
    begin : g_crd_ext
        assign ld_x = {{(COORD_BITS-POS_W){in_item.pos_x[POS_W-1]}}, in_item.pos_x};
        assign ld_y = {{(COORD_BITS-POS_W){in_item.pos_y[POS_W-1]}}, in_item.pos_y};
        assign ld_z = {{(COORD_BITS-POS_W){in_item.pos_z[POS_W-1]}}, in_item.pos_z};
    end

    // Memory addressing; component k sits at bit k*width, x lowest
    always_comb
    begin
        ld_addr = IDX_W'(in_item.vertex_index);
        case (step_reg[2:1])
            2'd0:    corner_addr = IDX_W'(item_reg.corner_a);
            2'd1:    corner_addr = IDX_W'(item_reg.corner_b);
            default: corner_addr = IDX_W'(item_reg.corner_c);
        endcase
        case (step_reg[1:0])
            2'd0:    vert_raddr = IDX_W'(item_reg.corner_a);
            2'd1:    vert_raddr = IDX_W'(item_reg.corner_b);
            default: vert_raddr = IDX_W'(item_reg.corner_c);
        endcase
        if (state_reg == S_READ)
        begin
            vert_raddr = IDX_W'(item_reg.vertex_index);
        end
        sum_raddr = (state_reg == S_READ) ? IDX_W'(item_reg.vertex_index) : corner_addr;
        vert_we   = in_acc && (in_item.opcode == mvna_pkg::OP_LOAD) && vi_ok;
        acc_we    = (state_reg == S_ACC) && step_reg[0];
        sum_we    = vert_we || acc_we;
    end

    mvna_ram #(.WIDTH(VR_W), .DEPTH(MAX_VERTS)) u_vert_ram (
        .clk   (clk),
        .we    (vert_we),
        .waddr (ld_addr),
        .wdata ({ld_z, ld_y, ld_x}),
        .raddr (vert_raddr),
        .rdata (vert_rdata)
    );

    mvna_ram #(.WIDTH(SR_W), .DEPTH(MAX_VERTS)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (vert_we ? ld_addr : corner_addr),
        .wdata (vert_we ? '0 : acc_data),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    // Edge vectors u = c - a and v = b - a
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            u_next[k] = $signed({vert_rdata[k*COORD_BITS+COORD_BITS-1],
                                 vert_rdata[k*COORD_BITS +: COORD_BITS]})
                      - $signed({va_reg[k*COORD_BITS+COORD_BITS-1],
                                 va_reg[k*COORD_BITS +: COORD_BITS]});
            v_next[k] = $signed({vb_reg[k*COORD_BITS+COORD_BITS-1],
                                 vb_reg[k*COORD_BITS +: COORD_BITS]})
                      - $signed({va_reg[k*COORD_BITS+COORD_BITS-1],
                                 va_reg[k*COORD_BITS +: COORD_BITS]});
        end
    end

    // Cross product operand schedule on the shared multiplier
    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                cr_a = MUL_W'(u_reg[1]);
                cr_b = MUL_W'(v_reg[2]);
            end
            3'd1:
            begin
                cr_a = MUL_W'(u_reg[2]);
                cr_b = MUL_W'(v_reg[1]);
            end
            3'd2:
            begin
                cr_a = MUL_W'(u_reg[2]);
                cr_b = MUL_W'(v_reg[0]);
            end
            3'd3:
            begin
                cr_a = MUL_W'(u_reg[0]);
                cr_b = MUL_W'(v_reg[2]);
            end
            3'd4:
            begin
                cr_a = MUL_W'(u_reg[0]);
                cr_b = MUL_W'(v_reg[1]);
            end
            default:
            begin
                cr_a = MUL_W'(u_reg[1]);
                cr_b = MUL_W'(v_reg[0]);
            end
        endcase
        mul_a = (state_reg == S_CROSS) ? cr_a : nm_a;
        mul_b = (state_reg == S_CROSS) ? cr_b : nm_b;
        prod  = CR_W'(mul_p[2*D_W-1:0]);
        prod  = {mul_p[2*D_W-1], mul_p[2*D_W-1:0]};
    end

    mvna_mul #(.W(MUL_W)) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // Saturating add of the cross product into one corner's sums
    always_comb
    begin
        logic signed [SUM_BITS-1:0] s;
        logic signed [ACC_W-1:0]    t;
        for (int k = 0; k < 3; k++)
        begin
            s = sum_rdata[k*SUM_BITS +: SUM_BITS];
            t = $signed({{(ACC_W-SUM_BITS){s[SUM_BITS-1]}}, s})
              + $signed({{(ACC_W-CR_W){cr_reg[k][CR_W-1]}}, cr_reg[k]});
            if ((&t[ACC_W-1:SUM_BITS-1]) || !(|t[ACC_W-1:SUM_BITS-1]))
            begin
                acc_data[k*SUM_BITS +: SUM_BITS] = t[SUM_BITS-1:0];
            end
            else
            begin
                acc_data[k*SUM_BITS +: SUM_BITS] =
                    {t[ACC_W-1], {(SUM_BITS-1){~t[ACC_W-1]}}};
            end
        end
    end

    // Vector handed to the normaliser
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (water_mode_reg)
            begin
                vec[k] = item_vi_ok
                    ? $signed({{(VEC_W-COORD_BITS){vert_rdata[k*COORD_BITS+COORD_BITS-1]}},
                               vert_rdata[k*COORD_BITS +: COORD_BITS]})
                    : '0;
            end
            else
            begin
                vec[k] = item_vi_ok
                    ? $signed({{(VEC_W-SUM_BITS){sum_rdata[k*SUM_BITS+SUM_BITS-1]}},
                               sum_rdata[k*SUM_BITS +: SUM_BITS]})
                    : '0;
            end
        end
        if (water_mode_reg)
        begin
            vec[0] = vec[0] + $signed({{(VEC_W-POS_W){offset_x_reg[POS_W-1]}}, offset_x_reg});
            vec[1] = vec[1] + $signed({{(VEC_W-POS_W){offset_y_reg[POS_W-1]}}, offset_y_reg});
            vec[2] = vec[2] + $signed({{(VEC_W-POS_W){offset_z_reg[POS_W-1]}}, offset_z_reg});
        end
        norm_start = (state_reg == S_READ) && step_reg[0];
    end

    mvna_norm #(.VEC_W(VEC_W), .MUL_W(MUL_W)) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vec_x (vec[0]),
        .vec_y (vec[1]),
        .vec_z (vec[2]),
        .mul_a (nm_a),
        .mul_b (nm_b),
        .mul_p (mul_p),
        .done  (norm_done),
        .res   (norm_res)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            water_mode_reg <= 1'b0;
            flat_world_reg <= 1'b0;
            offset_x_reg   <= '0;
            offset_y_reg   <= '0;
            offset_z_reg   <= '0;
            vcount_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mvna_pkg::CFG_WATER:  water_mode_reg <= cfg_data[0];
                mvna_pkg::CFG_FLAT:   flat_world_reg <= cfg_data[0];
                mvna_pkg::CFG_OFS_X:  offset_x_reg   <= cfg_data;
                mvna_pkg::CFG_OFS_Y:  offset_y_reg   <= cfg_data;
                mvna_pkg::CFG_OFS_Z:  offset_z_reg   <= cfg_data;
                mvna_pkg::CFG_VCOUNT: vcount_reg     <= cfg_data[mvna_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    if (in_acc)
                    begin
                        case (in_item.opcode)
                            mvna_pkg::OP_TRI:
                            begin
                                if (!skip_tri)
                                begin
                                    state_reg <= S_TRI;
                                end
                            end
                            mvna_pkg::OP_READ: state_reg <= S_READ;
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_TRI:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd3)
                    begin
                        state_reg <= S_CROSS;
                        step_reg  <= '0;
                    end
                end
                S_CROSS:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd6)
                    begin
                        state_reg <= S_ACC;
                        step_reg  <= '0;
                    end
                end
                S_ACC:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd5)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_READ:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (water_mode_reg && flat_world_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (step_reg[0])
                    begin
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (norm_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Item, edge, cross product and result registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_reg <= in_item;
        end
        if (state_reg == S_TRI)
        begin
            if (step_reg == 3'd1)
            begin
                va_reg <= vert_rdata;
            end
            if (step_reg == 3'd2)
            begin
                vb_reg <= vert_rdata;
            end
            if (step_reg == 3'd3)
            begin
                u_reg <= u_next;
                v_reg <= v_next;
            end
        end
        if (state_reg == S_CROSS)
        begin
            // first product of a pair is held, the second is subtracted from it
            if (step_reg[0])
            begin
                pm_reg <= prod;
            end
            else if (step_reg != 3'd0)
            begin
                cr_reg[step_reg[2:1] - 2'd1] <= pm_reg - prod;
            end
        end
        if (state_reg == S_READ)
        begin
            res_reg <= '{normal_x: '0, normal_y: '0,
                         normal_z: $signed(mvna_pkg::Q15_MAX),
                         normal_index: item_reg.vertex_index, zero_normal: 1'b0};
        end
        if ((state_reg == S_NORM) && norm_done)
        begin
            res_reg <= '{normal_x: norm_res.x, normal_y: norm_res.y, normal_z: norm_res.z,
                         normal_index: item_reg.vertex_index, zero_normal: norm_res.zero};
        end
        if ((state_reg == S_OUT) && (!out_valid_reg || !out_stall))
        begin
            out_item_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Checks
    `ASSERT_IMPL(a_norm_done_in_norm, norm_done, state_reg == S_NORM,
                 "normaliser finished outside the wait state")
    `ASSERT_IMPL(a_acc_write_phase, sum_we && !vert_we,
                 (state_reg == S_ACC) && step_reg[0],
                 "sum write outside the triangle write phase")
    `ASSERT_NEXT(a_out_loaded, (state_reg == S_OUT) && (!out_valid_reg || !out_stall),
                 out_valid_reg && (state_reg == S_IDLE),
                 "result not moved to the output register")

endmodule

`default_nettype wire

/* tb/mesh_vertex_normal_accumulator_tb.sv */
// Self-checking testbench for the vertex normal accumulator.
// Depends on mvna_pkg and the RTL; a scoreboard class predicts every read.
`timescale 1ns / 1ps

module mesh_vertex_normal_accumulator_tb;

    import mvna_pkg::*;

    localparam int NVERT = 1024;
    localparam logic [OPC_W-1:0] OP_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 200;
    localparam int LONG_HOLD = 600;

    // Scoreboard: own copy of vertices, sums and registers
    class normal_scoreboard;
        longint vert_x[NVERT], vert_y[NVERT], vert_z[NVERT];
        longint sum_x[NVERT], sum_y[NVERT], sum_z[NVERT];
        bit water, flat;
        longint ofs_x, ofs_y, ofs_z;
        int unsigned vcount;
        out_item_t expected_q[$];
        int mismatches;

        function new();
            water = 0; flat = 0; ofs_x = 0; ofs_y = 0; ofs_z = 0; vcount = 0;
            mismatches = 0;
            foreach (vert_x[i])
            begin
                vert_x[i] = 0; vert_y[i] = 0; vert_z[i] = 0;
                sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_WATER:  water = d[0];
                CFG_FLAT:   flat = d[0];
                CFG_OFS_X:  ofs_x = longint'($signed(d[19:0]));
                CFG_OFS_Y:  ofs_y = longint'($signed(d[19:0]));
                CFG_OFS_Z:  ofs_z = longint'($signed(d[19:0]));
                CFG_VCOUNT: vcount = d[10:0];
                default: ;
            endcase
        endfunction

        // Saturate at the 56-bit signed limits
        function longint clamp_add(longint s, longint d);
            longint smax, smin;
            smax = (longint'(1) <<< 55) - 1;
            smin = -smax - 1;
            if (d > 0 && s > smax - d) return smax;
            if (d < 0 && s < smin - d) return smin;
            return s + d;
        endfunction

        function longint unsigned int_root(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function logic [Q15_W-1:0] to_q15(longint unsigned m, longint v, longint unsigned n);
            longint unsigned q;
            q = (m * 32768 + n / 2) / n;
            if (q > 32767) q = 32767;
            return (v < 0) ? Q15_W'(-q) : Q15_W'(q);
        endfunction

        // Scale into [2^29, 2^30), integer root, rounded divides
        function void unit_vector(longint x, longint y, longint z, inout out_item_t r);
            longint unsigned mx, my, mz, m, n;
            mx = (x < 0) ? -x : x;
            my = (y < 0) ? -y : y;
            mz = (z < 0) ? -z : z;
            m = (mx > my) ? mx : my;
            if (mz > m) m = mz;
            if (m == 0)
            begin
                r.normal_x = '0; r.normal_y = '0; r.normal_z = '0; r.zero_normal = 1'b1;
                return;
            end
            while (m >= (64'd1 << NORM_HI))
            begin
                mx = mx >> 1; my = my >> 1; mz = mz >> 1; m = m >> 1;
            end
            while (m < (64'd1 << NORM_LO))
            begin
                mx = mx << 1; my = my << 1; mz = mz << 1; m = m << 1;
            end
            n = int_root(mx * mx + my * my + mz * mz);
            r.normal_x = to_q15(mx, x, n);
            r.normal_y = to_q15(my, y, n);
            r.normal_z = to_q15(mz, z, n);
            r.zero_normal = 1'b0;
        endfunction

        function void note_item(in_item_t it);
            int a, b, c, vi;
            longint ux, uy, uz, wx, wy, wz, nx, ny, nz;
            out_item_t r;
            vi = it.vertex_index;
            case (it.opcode)
                OP_LOAD:
                begin
                    vert_x[vi] = longint'(it.pos_x);
                    vert_y[vi] = longint'(it.pos_y);
                    vert_z[vi] = longint'(it.pos_z);
                    sum_x[vi] = 0; sum_y[vi] = 0; sum_z[vi] = 0;
                end
                OP_TRI:
                begin
                    a = it.corner_a; b = it.corner_b; c = it.corner_c;
                    if (a < vcount && b < vcount && c < vcount)
                    begin
                        ux = vert_x[c] - vert_x[a]; uy = vert_y[c] - vert_y[a];
                        uz = vert_z[c] - vert_z[a];
                        wx = vert_x[b] - vert_x[a]; wy = vert_y[b] - vert_y[a];
                        wz = vert_z[b] - vert_z[a];
                        nx = uy * wz - uz * wy;
                        ny = uz * wx - ux * wz;
                        nz = ux * wy - uy * wx;
                        sum_x[a] = clamp_add(sum_x[a], nx);
                        sum_y[a] = clamp_add(sum_y[a], ny);
                        sum_z[a] = clamp_add(sum_z[a], nz);
                        sum_x[b] = clamp_add(sum_x[b], nx);
                        sum_y[b] = clamp_add(sum_y[b], ny);
                        sum_z[b] = clamp_add(sum_z[b], nz);
                        sum_x[c] = clamp_add(sum_x[c], nx);
                        sum_y[c] = clamp_add(sum_y[c], ny);
                        sum_z[c] = clamp_add(sum_z[c], nz);
                    end
                end
                OP_READ:
                begin
                    r.normal_index = it.vertex_index;
                    if (water && flat)
                    begin
                        r.normal_x = '0; r.normal_y = '0; r.normal_z = Q15_MAX;
                        r.zero_normal = 1'b0;
                    end
                    else if (water)
                        unit_vector(vert_x[vi] + ofs_x, vert_y[vi] + ofs_y,
                                    vert_z[vi] + ofs_z, r);
                    else
                        unit_vector(sum_x[vi], sum_y[vi], sum_z[vi], r);
                    expected_q.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected normal for vertex %0d", got.normal_index);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got !== exp_r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("normal mismatch: exp idx %0d (%0d,%0d,%0d) z%0b, got idx %0d (%0d,%0d,%0d) z%0b",
                             exp_r.normal_index, exp_r.normal_x, exp_r.normal_y,
                             exp_r.normal_z, exp_r.zero_normal, got.normal_index,
                             got.normal_x, got.normal_y, got.normal_z, got.zero_normal);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_item;
    logic out_valid;
    logic out_stall;
    out_item_t out_item;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    normal_scoreboard sb;
    bit loaded[NVERT];
    int loaded_list[$];
    bit quiet;
    bit hold_req;

    mesh_vertex_normal_accumulator u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_item);
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                n = 0;
                while (n < LONG_HOLD)
                begin
                    @(posedge clk);
                    n++;
                end
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("mesh_vertex_normal_accumulator regression: fail");
        $finish;
    end

    task automatic send_item(in_item_t it);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        sb.note_item(it);
        if (it.opcode == OP_LOAD && !loaded[it.vertex_index])
        begin
            loaded[it.vertex_index] = 1'b1;
            loaded_list.push_back(it.vertex_index);
        end
    endtask

    // Drain outstanding reads, then let triangle work finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.apply_config(idx, d);
    endtask

    function automatic in_item_t make_item(logic [OPC_W-1:0] op, int vi,
                                           int px, int py, int pz, int a, int b, int c);
        in_item_t it;
        it.opcode = op;
        it.vertex_index = vi;
        it.pos_x = px; it.pos_y = py; it.pos_z = pz;
        it.corner_a = a; it.corner_b = b; it.corner_c = c;
        return it;
    endfunction

    function automatic int rand_coord();
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 2000) - 1000;
        return int'($signed(20'($urandom)));
    endfunction

    // Pick a loaded vertex below the count, or -1 if eight random picks all miss
    function automatic int pick_corner();
        int cand;
        repeat (8)
        begin
            cand = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            if (cand < sb.vcount) return cand;
        end
        return -1;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int sel, a, b, c;
        sel = $urandom_range(0, 99);
        it = make_item(OP_SPARE, $urandom_range(0, NVERT - 1), rand_coord(), rand_coord(),
                       rand_coord(), $urandom_range(0, NVERT - 1),
                       $urandom_range(0, NVERT - 1), $urandom_range(0, NVERT - 1));
        if (sel < 4)
            return it;
        if (sel < 30)
        begin
            it.opcode = OP_LOAD;
            if ($urandom_range(0, 3) != 0) it.vertex_index = $urandom_range(0, 31);
            return it;
        end
        if (sel < 70)
        begin
            it.opcode = OP_TRI;
            // skipped triangle: one corner at or above the count
            if (sb.vcount < NVERT && $urandom_range(0, 5) == 0)
            begin
                it.corner_b = $urandom_range(sb.vcount, NVERT - 1);
                return it;
            end
            a = pick_corner(); b = pick_corner(); c = pick_corner();
            if (a >= 0 && b >= 0 && c >= 0)
            begin
                it.corner_a = a; it.corner_b = b; it.corner_c = c;
                return it;
            end
        end
        it.opcode = OP_READ;
        if (!(sb.water && sb.flat))
            it.vertex_index = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        return it;
    endfunction

    task automatic random_phase(int count);
        repeat (count) send_item(random_item());
    endtask

    initial
    begin
        int px, py, pz;
        sb = new();
        quiet = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_WATER;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_VCOUNT, 20'd1024);

        // Directed: coordinate extremes, every opcode, degenerate and zero sums
        send_item(make_item(OP_LOAD, 0, 524287, 524287, 524287, 0, 0, 0));
        send_item(make_item(OP_LOAD, 1, -524288, -524288, -524288, 0, 0, 0));
        send_item(make_item(OP_LOAD, 2, 0, 524287, -524288, 0, 0, 0));
        send_item(make_item(OP_LOAD, 1023, -524288, 524287, 0, 0, 0, 0));
        send_item(make_item(OP_LOAD, 5, 123, -456, 789, 0, 0, 0));
        send_item(make_item(OP_LOAD, 7, 1, 2, 3, 0, 0, 0));
        send_item(make_item(OP_SPARE, 1023, -1, -1, -1, 1023, 1023, 1023));
        send_item(make_item(OP_TRI, 0, 0, 0, 0, 0, 1, 2));
        send_item(make_item(OP_TRI, 0, 0, 0, 0, 1023, 2, 5));
        send_item(make_item(OP_TRI, 0, 0, 0, 0, 0, 0, 1));
        send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 1023, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 5, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 7, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_READ, 2, 0, 0, 0, 0, 0, 0));

        // Long receiver hold-off while reads keep coming
        hold_req = 1'b1;
        repeat (6) send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        wait_idle();

        random_phase(300);
        // sender pause until every read has returned
        wait_idle();

        write_reg(CFG_VCOUNT, 20'd40);
        random_phase(250);
        wait_idle();

        write_reg(CFG_WATER, 20'd1);
        write_reg(CFG_FLAT, 20'd1);
        random_phase(150);
        wait_idle();

        write_reg(CFG_FLAT, 20'd0);
        write_reg(CFG_OFS_X, 20'h7FFFF);
        write_reg(CFG_OFS_Y, 20'h80000);
        write_reg(CFG_OFS_Z, 20'h7FFFF);
        random_phase(150);
        wait_idle();

        write_reg(CFG_OFS_X, 20'($urandom));
        write_reg(CFG_OFS_Y, 20'($urandom));
        write_reg(CFG_OFS_Z, 20'($urandom));
        random_phase(150);
        wait_idle();

        write_reg(CFG_WATER, 20'd0);
        write_reg(CFG_VCOUNT, 20'd0);
        random_phase(150);
        wait_idle();

        write_reg(CFG_VCOUNT, 20'($urandom_range(1, 1024)));
        random_phase(250);
        wait_idle();

        // Final stretch without idling: drive the corner sums into saturation
        quiet = 1'b1;
        write_reg(CFG_VCOUNT, 20'd1024);
        send_item(make_item(OP_LOAD, 1000, -524288, -524288, 0, 0, 0, 0));
        send_item(make_item(OP_LOAD, 1001, 524287, -524288, 0, 0, 0, 0));
        send_item(make_item(OP_LOAD, 1002, -524288, 524287, 0, 0, 0, 0));
        repeat (33000) send_item(make_item(OP_TRI, 0, 0, 0, 0, 1000, 1001, 1002));
        send_item(make_item(OP_READ, 1000, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_TRI, 0, 0, 0, 0, 1000, 1002, 1001));
        send_item(make_item(OP_READ, 1001, 0, 0, 0, 0, 0, 0));
        random_phase(100);
        wait_idle();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("mesh_vertex_normal_accumulator regression: pass");
        else
            $display("mesh_vertex_normal_accumulator regression: fail");
        $finish;
    end

endmodule
